// File: rtl/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// shared types and constants for the homogeneous vertex transform unit
// ----------------------------------------------------------------------------
package hvt_pkg;

    localparam int COMP_W     = 32;              // Q-format component width
    localparam int PROD_W     = 2 * COMP_W;      // one full product
    localparam int PAIR_W     = PROD_W + 1;      // sum of two products
    localparam int SUM_W      = PROD_W + 2;      // sum of four products
    localparam int NUM_COMP   = 4;               // x, y, z, w
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LANE_LATENCY = 4;             // product, pair, sum, saturate

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [NUM_COMP-1:0] vec4_t;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_LOW  = 3'd0,
        REG_ROW0_HIGH = 3'd1,
        REG_ROW1_LOW  = 3'd2,
        REG_ROW1_HIGH = 3'd3,
        REG_ROW2_LOW  = 3'd4,
        REG_ROW2_HIGH = 3'd5,
        REG_ROW3_LOW  = 3'd6,
        REG_ROW3_HIGH = 3'd7
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;

    // identity matrix after reset
    function automatic logic [CFG_DATA_W-1:0] cfg_reset_value(input cfg_reg_t idx);
        logic [CFG_DATA_W-1:0] val;
        case (idx)
            REG_ROW0_LOW:  val = ONE_LOW;
            REG_ROW1_LOW:  val = ONE_HIGH;
            REG_ROW2_HIGH: val = ONE_LOW;
            REG_ROW3_HIGH: val = ONE_HIGH;
            default:       val = '0;
        endcase
        return val;
    endfunction

    // per-lane result handed to the merge stage
    typedef struct packed {
        comp_t value;
        logic  sat;
    } lane_res_t;

endpackage

// File: rtl/hvt_lane.sv
// ----------------------------------------------------------------------------
// hvt_lane
// one output component: four-term dot product, shift and saturate
// ----------------------------------------------------------------------------
module hvt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  hvt_pkg::vec4_t    vtx,
    input  hvt_pkg::vec4_t    coef,
    output hvt_pkg::lane_res_t res
);

    localparam int SUM_W  = hvt_pkg::SUM_W;
    localparam int COMP_W = hvt_pkg::COMP_W;

    logic signed [hvt_pkg::PROD_W-1:0] prod_reg [hvt_pkg::NUM_COMP];
    logic signed [hvt_pkg::PROD_W-1:0] prod_next [hvt_pkg::NUM_COMP];
    logic signed [hvt_pkg::PAIR_W-1:0] pair_reg [2];
    logic signed [hvt_pkg::PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]           sum_reg;
    logic signed [SUM_W-1:0]           sum_next;
    logic signed [SUM_W-1:0]           shifted;
    logic                              fits;
    hvt_pkg::lane_res_t                res_reg;
    hvt_pkg::lane_res_t                res_next;

    always_comb
    begin
        for (int r = 0; r < hvt_pkg::NUM_COMP; r++)
        begin
            prod_next[r] = vtx[r] * coef[r];
        end
        pair_next[0] = prod_reg[0] + prod_reg[1];
        pair_next[1] = prod_reg[2] + prod_reg[3];
        sum_next     = pair_reg[0] + pair_reg[1];
    end

    // floor shift, then the upper bits must all match the sign of the result
    always_comb
    begin
        shifted = sum_reg >>> FRAC_BITS;
        fits    = (&shifted[SUM_W-1:COMP_W-1]) || !(|shifted[SUM_W-1:COMP_W-1]);
        if (fits)
        begin
            res_next.value = shifted[COMP_W-1:0];
            res_next.sat   = 1'b0;
        end
        else
        begin
            res_next.value = shifted[SUM_W-1] ? {1'b1, {(COMP_W-1){1'b0}}}
                                              : {1'b0, {(COMP_W-1){1'b1}}};
            res_next.sat   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        pair_reg <= pair_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

// File: rtl/hvt_merge.sv
// ----------------------------------------------------------------------------
// hvt_merge
// gathers the lane results into one output item with a common overflow flag
// ----------------------------------------------------------------------------
module hvt_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  hvt_pkg::lane_res_t lane_res [hvt_pkg::NUM_COMP],
    output logic               done,
    output hvt_pkg::vec4_t     comp,
    output logic               overflow
);

    logic           done_reg;
    logic           ovf_reg;
    logic           ovf_next;
    hvt_pkg::vec4_t comp_reg;
    hvt_pkg::vec4_t comp_next;

    always_comb
    begin
        ovf_next = 1'b0;
        for (int c = 0; c < hvt_pkg::NUM_COMP; c++)
        begin
            comp_next[c] = lane_res[c].value;
            ovf_next     = ovf_next | lane_res[c].sat;
        end
        ovf_next = ovf_next & valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        comp_reg <= comp_next;
    end

    assign done     = done_reg;
    assign overflow = ovf_reg;
    assign comp     = comp_reg;

endmodule

// File: rtl/homogeneous_vertex_transform_unit.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_unit
// homogeneous vertex times 4x4 matrix, signed fixed point, one vertex a cycle
// ----------------------------------------------------------------------------
// Takes one vertex (x, y, z, w) per clock on start and returns the vertex
// times the configured 4x4 matrix, as a one-cycle done strobe with
// out_x..out_w and overflow. busy never rises, so a new item
// may be started every cycle; the receiver cannot stall, so each result
// must be captured in the cycle done is high. The result passes through
// the input register, the 32x32 multiplier stage, two adder stages, the
// shift/saturate stage and the output register. Components and matrix
// elements are signed with FRAC_BITS fraction bits; the exact sum is
// floor-shifted and saturated to 32 bits, overflow flagging any clipped
// component. The matrix resets to identity; write registers only while no
// item is in flight.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // item input
    input  logic                             start,
    output logic                             busy,
    input  logic signed [hvt_pkg::COMP_W-1:0] in_x,
    input  logic signed [hvt_pkg::COMP_W-1:0] in_y,
    input  logic signed [hvt_pkg::COMP_W-1:0] in_z,
    input  logic signed [hvt_pkg::COMP_W-1:0] in_w,

    // result output
    output logic                             done,
    output logic signed [hvt_pkg::COMP_W-1:0] out_x,
    output logic signed [hvt_pkg::COMP_W-1:0] out_y,
    output logic signed [hvt_pkg::COMP_W-1:0] out_z,
    output logic signed [hvt_pkg::COMP_W-1:0] out_w,
    output logic                             overflow,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hvt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hvt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NC = hvt_pkg::NUM_COMP;

    logic                              accept;
    logic [hvt_pkg::CFG_DATA_W-1:0]    cfg_reg [hvt_pkg::NUM_REGS];
    hvt_pkg::vec4_t                    vtx_reg;
    hvt_pkg::vec4_t                    vtx_next;
    // one valid bit per pipeline stage up to the lane outputs
    logic [hvt_pkg::LANE_LATENCY:0]    vld_reg;
    logic [hvt_pkg::LANE_LATENCY:0]    vld_next;
    hvt_pkg::vec4_t                    coef [NC];
    hvt_pkg::lane_res_t                lane_res [NC];
    hvt_pkg::vec4_t                    comp;

    // never stalls on either side
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hvt_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= hvt_pkg::cfg_reset_value(
                                  hvt_pkg::cfg_reg_t'(i[hvt_pkg::CFG_IDX_W-1:0]));
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // column c of the matrix feeds lane c; element (r, c) sits in register
    // 2r + c/2, low or high word by the parity of c
    for (genvar gc = 0; gc < NC; gc++)
    begin : g_coef
        for (genvar gr = 0; gr < NC; gr++)
        begin : g_row
            assign coef[gc][gr] =
                cfg_reg[2 * gr + gc / 2][(gc % 2) * hvt_pkg::COMP_W +: hvt_pkg::COMP_W];
        end
    end

    // input register and valid pipe
    always_comb
    begin
        vtx_next    = vtx_reg;
        if (accept)
        begin
            vtx_next[0] = in_x;
            vtx_next[1] = in_y;
            vtx_next[2] = in_z;
            vtx_next[3] = in_w;
        end
        vld_next = {vld_reg[hvt_pkg::LANE_LATENCY-1:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vtx_reg <= vtx_next;
    end

    // one lane per output component
    for (genvar gl = 0; gl < NC; gl++)
    begin : g_lane
        hvt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .vtx  (vtx_reg),
            .coef (coef[gl]),
            .res  (lane_res[gl])
        );
    end

    // combine lane results and register the output item
    hvt_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (vld_reg[hvt_pkg::LANE_LATENCY]),
        .lane_res (lane_res),
        .done     (done),
        .comp     (comp),
        .overflow (overflow)
    );

    assign out_x = comp[0];
    assign out_y = comp[1];
    assign out_z = comp[2];
    assign out_w = comp[3];

endmodule

// File: rtl/hvt_checker.sv
// ----------------------------------------------------------------------------
// hvt_checker
// port-level checks on the vertex transform unit
// ----------------------------------------------------------------------------
module hvt_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic overflow,
    input logic cfg_valid,
    input logic cfg_ready
);

    localparam int LATENCY = hvt_pkg::LANE_LATENCY + 2;

    // every accepted item comes out after a fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not produce a result on time");

    // no result without an item accepted at the matching time
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted item");

    // overflow flag belongs to a result only
    a_ovf_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        overflow |-> done)
        else $error("overflow raised outside a result cycle");

    // the unit never holds off items or writes
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && (!cfg_valid || cfg_ready))
        else $error("busy or configuration stall observed");

endmodule

bind homogeneous_vertex_transform_unit hvt_checker u_hvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .overflow  (overflow),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
